/* rtl/pspr_pkg.sv */
// Shared types and constants for the PCM sample packer ring buffer.
// Used by pspr_fmt, the top-level module and the testbench; depends on nothing.
`default_nettype none

package pspr_pkg;

    localparam int BUFFER_BYTES_DEF = 8192;
    localparam int READ_MAX_DEF     = 64;

    localparam int SAMPLE_W   = 24;
    localparam int WORD_W     = 32;
    localparam int FILL_W     = 13;
    localparam int LEN_W      = 7;
    localparam int ACTION_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_WORD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN     = 2'd2;

    localparam logic [2:0] BYTES_PER_WORD_RST = 3'd2;

    typedef struct packed {
        logic [2:0] bytes_per_word;
        logic       unsigned_mode;
        logic       big_endian;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [2:0]        nbytes;
    } fmt_t;

endpackage

`default_nettype wire

/* rtl/pspr_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module pspr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/pspr_fmt.sv */
// Sample formatter: turns a Q1.23 sample into a PCM word of one to four bytes.
// Depends on pspr_pkg.
`default_nettype none

module pspr_fmt (
    input  wire pspr_pkg::cfg_t                     cfg,
    input  wire logic signed [pspr_pkg::SAMPLE_W-1:0] sample_value,
    output pspr_pkg::fmt_t                          fmt
);

    logic [2:0]                    nbytes;
    logic signed [24:0]            sx;
    logic signed [24:0]            q8;
    logic signed [24:0]            q16;
    logic [23:0]                   u;
    logic [pspr_pkg::WORD_W-1:0]   word;

    always_comb
    begin
        unique case (cfg.bytes_per_word) inside
            3'd0, 3'd1:             nbytes = 3'd1;
            3'd2:                   nbytes = 3'd2;
            3'd3:                   nbytes = 3'd3;
            3'd4, 3'd5, 3'd6, 3'd7: nbytes = 3'd4;
            default:                nbytes = 3'd4;
        endcase
    end

    // Negative samples get a bias so the arithmetic shift rounds toward zero.
    assign sx  = {sample_value[23], sample_value};
    assign q8  = (sx + (sample_value[23] ? 25'sh0000FF : 25'sh0)) >>> 8;
    assign q16 = (sx + (sample_value[23] ? 25'sh00FFFF : 25'sh0)) >>> 16;
    assign u   = {~sample_value[23], sample_value[22:0]};

    always_comb
    begin
        word = '0;
        if (cfg.unsigned_mode)
        begin
            unique case (nbytes)
                3'd1:    word = {24'd0, u[23:16]};
                3'd2:    word = {16'd0, u[23:8]};
                3'd3:    word = {8'd0, u};
                default: word = {u, 8'd0};
            endcase
        end
        else
        begin
            unique case (nbytes)
                3'd1:    word = {24'd0, q16[7:0]};
                3'd2:    word = {16'd0, q8[15:0]};
                3'd3:    word = {8'd0, sample_value};
                default: word = {sample_value, 8'd0};
            endcase
        end
    end

    assign fmt.word   = word;
    assign fmt.nbytes = nbytes;

endmodule

`default_nettype wire

/* rtl/pcm_sample_packer_ring_buffer.sv */
// PCM sample packer with a circular byte buffer held in one byte-wide RAM.
// A push item holds busy high while it writes its word of one to four bytes,
// so a new push is accepted only after the last byte of the word is written.
// A read item passes the read state and the RAM read and result registers, then gives one byte per cycle.
// An empty or zero-length read gives its single result in the cycle after acceptance.
// A clear zeroes both pointers, and so does reset; the RAM needs no clearing pass.
// Results cannot be stalled; each appears for one cycle with strobe high.
`default_nettype none

module pcm_sample_packer_ring_buffer #(
    parameter int BUFFER_BYTES = pspr_pkg::BUFFER_BYTES_DEF,
    parameter int READ_MAX     = pspr_pkg::READ_MAX_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [pspr_pkg::ACTION_W-1:0]       action,
    input  wire logic signed [pspr_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic [pspr_pkg::LEN_W-1:0]          read_length,
    output logic                                     strobe,
    output logic [7:0]                               byte_value,
    output logic                                     byte_valid,
    output logic                                     last,
    output logic [pspr_pkg::FILL_W-1:0]              fill_level,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pspr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pspr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PTR_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W = $clog2(READ_MAX + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_BYTES - 1);
    localparam logic [PTR_W-1:0] PTR_SPAN = PTR_W'(BUFFER_BYTES);
    localparam logic [pspr_pkg::LEN_W-1:0] LEN_MAX = pspr_pkg::LEN_W'(READ_MAX);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PUSH = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [PTR_W-1:0]            wp_reg, wp_next;
    logic [PTR_W-1:0]            rp_reg, rp_next;
    logic [pspr_pkg::WORD_W-1:0] word_reg, word_next;
    logic [2:0]                  n_reg, n_next;
    logic [1:0]                  idx_reg, idx_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic                        pend_ok_reg, pend_ok_next;
    logic                        pend_last_reg, pend_last_next;
    logic [PTR_W-1:0]            pend_fill_reg, pend_fill_next;
    pspr_pkg::cfg_t              cfg_reg, cfg_next;

    pspr_pkg::fmt_t              fmt;
    logic                        accept;
    logic [PTR_W-1:0]            fill_now;
    logic [pspr_pkg::LEN_W-1:0]  len_sat;
    logic [2:0]                  n_minus1;
    logic [1:0]                  byte_sel;
    logic                        ram_we;
    logic [7:0]                  ram_wdata;
    logic [7:0]                  ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    pspr_fmt u_fmt (
        .cfg          (cfg_reg),
        .sample_value (sample_value),
        .fmt          (fmt)
    );

    pspr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (wp_reg),
        .wr_data (ram_wdata),
        .rd_addr (rp_reg),
        .rd_data (ram_rdata)
    );

    assign busy      = (state_reg != ST_IDLE) || pend_valid_reg;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign fill_now = (wp_reg >= rp_reg) ? (wp_reg - rp_reg) : (wp_reg - rp_reg + PTR_SPAN);
    assign len_sat  = (read_length > LEN_MAX) ? LEN_MAX : read_length;
    assign n_minus1 = n_reg - 3'd1;
    assign byte_sel = cfg_reg.big_endian ? (n_minus1[1:0] - idx_reg) : idx_reg;
    assign ram_wdata = word_reg[{byte_sel, 3'b000} +: 8];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pspr_pkg::CFG_BYTES_PER_WORD: cfg_next.bytes_per_word = cfg_data;
                pspr_pkg::CFG_UNSIGNED_MODE:  cfg_next.unsigned_mode  = cfg_data[0];
                pspr_pkg::CFG_BIG_ENDIAN:     cfg_next.big_endian     = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        word_next       = word_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = 1'b0;
        pend_ok_next    = pend_ok_reg;
        pend_last_next  = pend_last_reg;
        pend_fill_next  = pend_fill_reg;
        ram_we          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        pspr_pkg::ACT_PUSH:
                        begin
                            word_next  = fmt.word;
                            n_next     = fmt.nbytes;
                            idx_next   = '0;
                            state_next = ST_PUSH;
                        end
                        pspr_pkg::ACT_READ:
                        begin
                            if ((len_sat == '0) || (fill_now == '0))
                            begin
                                pend_valid_next = 1'b1;
                                pend_ok_next    = 1'b0;
                                pend_last_next  = 1'b1;
                                pend_fill_next  = fill_now;
                            end
                            else
                            begin
                                if (32'(len_sat) < 32'(fill_now))
                                begin
                                    cnt_next = CNT_W'(len_sat);
                                end
                                else
                                begin
                                    cnt_next = CNT_W'(fill_now);
                                end
                                state_next = ST_READ;
                            end
                        end
                        pspr_pkg::ACT_CLEAR:
                        begin
                            wp_next = '0;
                            rp_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PUSH:
            begin
                ram_we   = 1'b1;
                wp_next  = ptr_inc(wp_reg);
                idx_next = idx_reg + 2'd1;
                if ({1'b0, idx_reg} == n_minus1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                rp_next         = ptr_inc(rp_reg);
                cnt_next        = cnt_reg - 1'b1;
                pend_valid_next = 1'b1;
                pend_ok_next    = 1'b1;
                pend_last_next  = (cnt_reg == CNT_W'(1));
                pend_fill_next  = fill_now - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            n_reg          <= 3'd1;
            pend_valid_reg <= 1'b0;
            cfg_reg        <= '{bytes_per_word: pspr_pkg::BYTES_PER_WORD_RST,
                                unsigned_mode: 1'b0, big_endian: 1'b0};
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            cfg_reg        <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        pend_ok_reg   <= pend_ok_next;
        pend_last_reg <= pend_last_next;
        pend_fill_reg <= pend_fill_next;
    end

    assign strobe     = pend_valid_reg;
    assign byte_value = pend_ok_reg ? ram_rdata : 8'd0;
    assign byte_valid = pend_ok_reg;
    assign last       = pend_last_reg;
    assign fill_level = pspr_pkg::FILL_W'(pend_fill_reg);

    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (cnt_reg != '0))
        else $error("read state entered with nothing left to drain");

    a_push_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> ({1'b0, idx_reg} < n_reg))
        else $error("push byte index ran past the word size");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("result followed the final item of a run");

    a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !byte_valid) |-> last)
        else $error("invalid result not marked as final");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg <= PTR_LAST) && (rp_reg <= PTR_LAST))
        else $error("ring pointer outside the buffer");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for pcm_sample_packer_ring_buffer: formats pushed samples, drains
// the byte ring and compares every result byte against a predictor kept in step with the block.
// Depends on the RTL package pspr_pkg and the top-level module only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W   = pspr_pkg::SAMPLE_W;
    localparam int FILL_W     = pspr_pkg::FILL_W;
    localparam int LEN_W      = pspr_pkg::LEN_W;
    localparam int ACTION_W   = pspr_pkg::ACTION_W;
    localparam int CFG_IDX_W  = pspr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = pspr_pkg::CFG_DATA_W;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int RING_BYTES    = pspr_pkg::BUFFER_BYTES_DEF;
    localparam int READ_LIMIT    = pspr_pkg::READ_MAX_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 230;
    localparam int FILL_PUSHES   = 40;

    localparam logic [ACTION_W-1:0]  ACT_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;

    typedef struct packed {
        logic [7:0]        value;
        logic              valid;
        logic              last;
        logic [FILL_W-1:0] fill;
    } pcm_byte_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [ACTION_W-1:0]        action = pspr_pkg::ACT_PUSH;
    logic signed [SAMPLE_W-1:0] sample_value = '0;
    logic [LEN_W-1:0]           read_length = '0;
    logic                       strobe;
    logic [7:0]                 byte_value;
    logic                       byte_valid;
    logic                       last;
    logic [FILL_W-1:0]          fill_level;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    logic [7:0]        ring_model [RING_BYTES];
    logic [FILL_W-1:0] wr_ptr;
    logic [FILL_W-1:0] rd_ptr;
    pspr_pkg::cfg_t    cfg_model;
    pcm_byte_t         pending_bytes [$];

    int errors = 0;
    int idle_cycles = 0;
    int n_push = 0;
    int n_read = 0;
    int n_clear = 0;
    int n_cfg = 0;
    int n_bytes = 0;
    int n_empty = 0;
    bit gaps_on = 1'b1;

    pcm_sample_packer_ring_buffer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .sample_value (sample_value),
        .read_length  (read_length),
        .strobe       (strobe),
        .byte_value   (byte_value),
        .byte_valid   (byte_valid),
        .last         (last),
        .fill_level   (fill_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic int word_size();
        if (cfg_model.bytes_per_word == 3'd0)
        begin
            return 1;
        end
        if (cfg_model.bytes_per_word > 3'd4)
        begin
            return 4;
        end
        return int'(cfg_model.bytes_per_word);
    endfunction

    function automatic logic [31:0] pcm_word(input logic signed [SAMPLE_W-1:0] smp, input int n);
        longint     s_ext;
        longint     q;
        int         bits;
        logic [63:0] mask;
        s_ext = smp;
        bits = 8 * n;
        mask = (64'd1 << bits) - 64'd1;
        if (cfg_model.unsigned_mode)
        begin
            q = s_ext + 64'sd8388608;
            if (bits < SAMPLE_W)
            begin
                q = q >>> (SAMPLE_W - bits);
            end
            else
            begin
                q = q <<< (bits - SAMPLE_W);
            end
        end
        else if (bits < SAMPLE_W)
        begin
            q = s_ext / (64'sd1 <<< (SAMPLE_W - bits));
        end
        else
        begin
            q = s_ext * (64'sd1 <<< (bits - SAMPLE_W));
        end
        return 32'(q & mask);
    endfunction

    task automatic model_push(input logic signed [SAMPLE_W-1:0] smp);
        int          n;
        int          sh;
        logic [31:0] w;
        n = word_size();
        w = pcm_word(smp, n);
        for (int i = 0; i < n; i++)
        begin
            sh = cfg_model.big_endian ? 8 * (n - 1 - i) : 8 * i;
            ring_model[wr_ptr] = 8'(w >> sh);
            wr_ptr = wr_ptr + 1'b1;
        end
        n_push++;
    endtask

    task automatic model_read(input logic [LEN_W-1:0] len_in);
        int                len;
        int                chunk;
        logic [FILL_W-1:0] fill;
        pcm_byte_t         b;
        len = (len_in > READ_LIMIT) ? READ_LIMIT : int'(len_in);
        fill = wr_ptr - rd_ptr;
        n_read++;
        if (len == 0 || fill == '0)
        begin
            b = '{value: 8'h00, valid: 1'b0, last: 1'b1, fill: fill};
            pending_bytes = {pending_bytes, b};
            n_empty++;
        end
        else
        begin
            chunk = (len < int'(fill)) ? len : int'(fill);
            for (int k = 0; k < chunk; k++)
            begin
                b.value = ring_model[rd_ptr];
                b.valid = 1'b1;
                b.last  = (k == chunk - 1);
                b.fill  = fill - FILL_W'(k + 1);
                rd_ptr = rd_ptr + 1'b1;
                pending_bytes = {pending_bytes, b};
                n_bytes++;
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    task automatic issue_item(input logic [ACTION_W-1:0] act,
                              input logic signed [SAMPLE_W-1:0] smp,
                              input logic [LEN_W-1:0] len);
        int gap;
        start        <= 1'b1;
        action       <= act;
        sample_value <= smp;
        read_length  <= len;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        case (act)
            pspr_pkg::ACT_PUSH:
            begin
                model_push(smp);
            end
            pspr_pkg::ACT_READ:
            begin
                model_read(len);
            end
            pspr_pkg::ACT_CLEAR:
            begin
                wr_ptr = '0;
                rd_ptr = '0;
                n_clear++;
            end
            default:
            begin
            end
        endcase
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp);
        issue_item(pspr_pkg::ACT_PUSH, smp, LEN_W'($urandom_range(0, 127)));
    endtask

    task automatic read_bytes(input logic [LEN_W-1:0] len);
        issue_item(pspr_pkg::ACT_READ, SAMPLE_W'($urandom()), len);
    endtask

    task automatic clear_ring();
        issue_item(pspr_pkg::ACT_CLEAR, SAMPLE_W'($urandom()), LEN_W'($urandom_range(0, 127)));
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            pspr_pkg::CFG_BYTES_PER_WORD:
            begin
                cfg_model.bytes_per_word = data;
            end
            pspr_pkg::CFG_UNSIGNED_MODE:
            begin
                cfg_model.unsigned_mode = data[0];
            end
            pspr_pkg::CFG_BIG_ENDIAN:
            begin
                cfg_model.big_endian = data[0];
            end
            default:
            begin
            end
        endcase
        n_cfg++;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] sb, input logic [CFG_DATA_W-1:0] um,
                              input logic [CFG_DATA_W-1:0] be, input bit poke_unused);
        wait_quiet();
        cfg_write(pspr_pkg::CFG_BYTES_PER_WORD, sb);
        cfg_write(pspr_pkg::CFG_UNSIGNED_MODE, um);
        cfg_write(pspr_pkg::CFG_BIG_ENDIAN, be);
        if (poke_unused)
        begin
            cfg_write(CFG_UNUSED_IDX, 3'b111);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return LEN_W'($urandom_range(1, 6));
        end
        if (r < 78)
        begin
            return '0;
        end
        if (r < 90)
        begin
            return LEN_W'($urandom_range(7, READ_LIMIT));
        end
        return LEN_W'($urandom_range(READ_LIMIT + 1, 127));
    endfunction

    task automatic test_empty_read();
        read_bytes(7'd5);
    endtask

    task automatic test_reset_format();
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(-24'sd1);
        push_sample(24'sd1);
        read_bytes(7'd64);
    endtask

    task automatic test_word_formats();
        set_config(3'd1, 3'd1, 3'd1, 1'b0);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);
        push_sample(24'sh123456);
        read_bytes(7'd64);
        set_config(3'd3, 3'd0, 3'd1, 1'b0);
        push_sample(-24'sd1);
        push_sample(SAMPLE_MIN);
        read_bytes(7'd0);
        read_bytes(7'd4);
        read_bytes(7'd100);
        set_config(3'd4, 3'd1, 3'd0, 1'b0);
        push_sample(-24'sd1);
        push_sample(SAMPLE_MAX);
        read_bytes(7'd127);
    endtask

    task automatic test_size_clamp();
        set_config(3'd0, 3'd0, 3'd1, 1'b1);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        set_config(3'd7, 3'd1, 3'd0, 1'b0);
        push_sample(-24'sd3);
        read_bytes(7'd64);
    endtask

    task automatic test_clear_and_ignored();
        push_sample(24'sh3A5C71);
        issue_item(ACT_UNUSED, SAMPLE_W'($urandom()), 7'd9);
        clear_ring();
        read_bytes(7'd3);
        push_sample(-24'sh2B1E0F);
        read_bytes(7'd64);
    endtask

    task automatic test_bulk_fill();
        set_config(3'd4, 3'd0, 3'd0, 1'b0);
        clear_ring();
        gaps_on = 1'b0;
        for (int i = 0; i < FILL_PUSHES; i++)
        begin
            push_sample(random_sample());
        end
        gaps_on = 1'b1;
        set_config(3'd3, 3'd1, 3'd1, 1'b0);
        push_sample(random_sample());
        read_bytes(7'd2);
        push_sample(random_sample());
        read_bytes(7'd8);
        push_sample(random_sample());
        read_bytes(7'd64);
    endtask

    task automatic test_random_traffic();
        int issued;
        int phase_len;
        int pick;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            set_config(CFG_DATA_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom_range(0, 7)),
                       CFG_DATA_W'($urandom_range(0, 7)), $urandom_range(0, 3) == 0);
            gaps_on = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(40, 90);
            for (int k = 0; k < phase_len && issued < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    push_sample(random_sample());
                    issued++;
                end
                else if (pick < 92)
                begin
                    read_bytes(random_length());
                    issued++;
                end
                else if (pick < 95)
                begin
                    clear_ring();
                    issued++;
                end
                else
                begin
                    issue_item(ACT_UNUSED, SAMPLE_W'($urandom()), LEN_W'($urandom_range(0, 127)));
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    function automatic void check_field(input string name, input logic [31:0] expv,
                                        input logic [31:0] actv);
        if (actv !== expv)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, expv, actv);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        pcm_byte_t exp_b;
        if (rst_n && strobe)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value 0x%0h",
                         $time, byte_value);
                $display("    valid %0b last %0b fill %0d", byte_valid, last, fill_level);
                errors++;
            end
            else
            begin
                exp_b = pending_bytes.pop_front();
                check_field("byte_value", 32'(exp_b.value), 32'(byte_value));
                check_field("byte_valid", 32'(exp_b.valid), 32'(byte_valid));
                check_field("last", 32'(exp_b.last), 32'(last));
                check_field("fill_level", 32'(exp_b.fill), 32'(fill_level));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending_bytes.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        wr_ptr = '0;
        rd_ptr = '0;
        cfg_model = '{bytes_per_word: pspr_pkg::BYTES_PER_WORD_RST, unsigned_mode: 1'b0,
                      big_endian: 1'b0};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_read();
        test_reset_format();
        test_word_formats();
        test_size_clamp();
        test_clear_and_ignored();
        test_bulk_fill();
        test_random_traffic();
        wait_quiet();
        $display("Covered %0d pushes, %0d reads, %0d clears and %0d register writes.",
                 n_push, n_read, n_clear, n_cfg);
        $display("Compared %0d ring bytes and %0d empty or zero-length reads.",
                 n_bytes, n_empty);
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
